// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/arc_pkg.sv -----
package arc_pkg;

  // Table size and significant address bits.
  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 48;

  localparam int AddrW = 48;
  localparam int LenW  = 32;
  localparam int IdxW  = $clog2(TABLE_ENTRIES);
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);

  localparam logic [AddrW-1:0] AddrMask = (ADDR_BITS >= AddrW) ? {AddrW{1'b1}} :
                                          AddrW'((64'd1 << ADDR_BITS) - 64'd1);

  // Request types.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CHECK  = 2'd3;

  // Status codes.
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_NOT_FOUND   = 3'd1;
  localparam logic [2:0] STS_NOT_FIRST   = 3'd2;
  localparam logic [2:0] STS_DOUBLE_FREE = 3'd3;
  localparam logic [2:0] STS_OVERFLOW    = 3'd4;
  localparam logic [2:0] STS_FULL        = 3'd5;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] found_base;
    logic [LenW-1:0]  found_length;
    logic             found_active;
  } rsp_t;

  // One stored region.
  typedef struct packed {
    logic             live;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] base;
  } entry_t;

endpackage

// ----- src/arc_ram.sv -----
module arc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/arc_front.sv -----
module arc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  arc_pkg::req_t req_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output arc_pkg::req_t q_data_o
);

  arc_pkg::req_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  arc_pkg::req_t in_masked;

  // Requests are masked to the significant address bits on the way in.
  always_comb begin
    in_masked         = req_i;
    in_masked.address = req_i.address & arc_pkg::AddrMask;
  end

  assign req_ready_o = (cnt_q != 2'd2);
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = slot_q[rd_ptr_q];
  assign push        = req_valid_i && req_ready_o;
  assign pop         = q_valid_o && q_ready_i;

  // Two-entry queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_masked;
    end
  end

endmodule

// ----- src/arc_back.sv -----
module arc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  arc_pkg::req_t q_data_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output arc_pkg::rsp_t rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam int         EntW   = $bits(arc_pkg::entry_t);
  localparam logic [arc_pkg::CntW-1:0] LastCnt = arc_pkg::CntW'(arc_pkg::TABLE_ENTRIES);

  logic [1:0]                       state_q, state_d;
  arc_pkg::req_t                    cur_q, cur_d;
  logic [arc_pkg::CntW-1:0]         rd_cnt_q, rd_cnt_d;
  logic                             rd_vld_q, rd_vld_d;
  logic [arc_pkg::IdxW-1:0]         rd_idx_q, rd_idx_d;
  logic [arc_pkg::TABLE_ENTRIES-1:0] used_q, used_d;
  logic                             ex_hit_q, ex_hit_d, fr_hit_q, fr_hit_d;
  logic                             pr_hit_q, pr_hit_d;
  logic [arc_pkg::IdxW-1:0]         ex_idx_q, ex_idx_d, fr_idx_q, fr_idx_d;
  arc_pkg::entry_t                  ex_q, ex_d, pr_q, pr_d;
  logic                             out_vld_q, out_vld_d;
  arc_pkg::rsp_t                    out_q, out_d;

  logic                     ram_re, ram_we;
  logic [arc_pkg::IdxW-1:0] ram_waddr;
  arc_pkg::entry_t          ram_wdata, ram_rdata;
  logic [EntW-1:0]          ram_rdata_raw;
  logic                     rd_used, fire;
  logic [arc_pkg::AddrW-1:0] off;
  logic [arc_pkg::LenW-1:0]  room;

  arc_ram #(.Width(EntW), .Depth(arc_pkg::TABLE_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_cnt_q[arc_pkg::IdxW-1:0]),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata   = arc_pkg::entry_t'(ram_rdata_raw);
  assign q_ready_o   = (state_q == S_IDLE);
  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;
  assign rd_used     = used_q[rd_idx_q];
  assign fire        = (state_q == S_FIN) && (!out_vld_q || rsp_ready_i);

  // Offset of the address into the predecessor region and the room left after it.
  assign off  = cur_q.address - pr_q.base;
  assign room = pr_q.len - off[arc_pkg::LenW-1:0];

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    rd_cnt_d  = rd_cnt_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_cnt_q[arc_pkg::IdxW-1:0];
    used_d    = used_q;
    ex_hit_d  = ex_hit_q;
    ex_idx_d  = ex_idx_q;
    ex_d      = ex_q;
    fr_hit_d  = fr_hit_q;
    fr_idx_d  = fr_idx_q;
    pr_hit_d  = pr_hit_q;
    pr_d      = pr_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_ready_i;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ex_idx_q;
    ram_wdata = '0;

    case (state_q)
      // Take the next request from the queue and reset the scan.
      S_IDLE: begin
        if (q_valid_i) begin
          cur_d    = q_data_i;
          rd_cnt_d = '0;
          ex_hit_d = 1'b0;
          fr_hit_d = 1'b0;
          pr_hit_d = 1'b0;
          state_d  = S_SCAN;
        end
      end

      // Read one entry a cycle and fold it into the exact, free and predecessor trackers.
      S_SCAN: begin
        if (rd_cnt_q != LastCnt) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_cnt_d = rd_cnt_q + arc_pkg::CntW'(1);
        end else if (!rd_vld_q) begin
          state_d = S_FIN;
        end
        if (rd_vld_q) begin
          if (rd_used && (ram_rdata.base == cur_q.address) && !ex_hit_q) begin
            ex_hit_d = 1'b1;
            ex_idx_d = rd_idx_q;
            ex_d     = ram_rdata;
          end
          if (!rd_used && !fr_hit_q) begin
            fr_hit_d = 1'b1;
            fr_idx_d = rd_idx_q;
          end
          if (rd_used && (ram_rdata.base <= cur_q.address) &&
              (!pr_hit_q || (ram_rdata.base > pr_q.base))) begin
            pr_hit_d = 1'b1;
            pr_d     = ram_rdata;
          end
        end
      end

      // Resolve the request, update the table and load the result register.
      S_FIN: begin
        if (fire) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
          out_d     = '0;
          out_d.status = arc_pkg::STS_NOT_FOUND;
          case (cur_q.req_type)
            arc_pkg::REQ_INSERT: begin
              ram_wdata.base = cur_q.address;
              ram_wdata.len  = cur_q.length;
              ram_wdata.live = 1'b1;
              if (ex_hit_q || fr_hit_q) begin
                ram_we    = 1'b1;
                ram_waddr = ex_hit_q ? ex_idx_q : fr_idx_q;
                used_d[ram_waddr] = 1'b1;
                out_d = '{arc_pkg::STS_OK, cur_q.address, cur_q.length, 1'b1};
              end else begin
                out_d.status = arc_pkg::STS_FULL;
              end
            end
            arc_pkg::REQ_FREE, arc_pkg::REQ_REMOVE: begin
              if (ex_hit_q) begin
                out_d = '{arc_pkg::STS_OK, ex_q.base, ex_q.len, ex_q.live};
                if (cur_q.req_type == arc_pkg::REQ_REMOVE) begin
                  used_d[ex_idx_q] = 1'b0;
                end else if (!ex_q.live) begin
                  out_d.status = arc_pkg::STS_DOUBLE_FREE;
                end else begin
                  ram_we         = 1'b1;
                  ram_wdata.base = ex_q.base;
                  out_d.found_length = '0;
                  out_d.found_active = 1'b0;
                end
              end else if (pr_hit_q &&
                           (off < {{(arc_pkg::AddrW-arc_pkg::LenW){1'b0}}, pr_q.len})) begin
                out_d = '{arc_pkg::STS_NOT_FIRST, pr_q.base, pr_q.len, pr_q.live};
              end
            end
            default: begin
              if (pr_hit_q &&
                  !(off > {{(arc_pkg::AddrW-arc_pkg::LenW){1'b0}}, pr_q.len})) begin
                out_d = '{arc_pkg::STS_OK, pr_q.base, pr_q.len, pr_q.live};
                if (cur_q.length > room) begin
                  out_d.status = arc_pkg::STS_OVERFLOW;
                end else if (!pr_q.live) begin
                  out_d.status = arc_pkg::STS_DOUBLE_FREE;
                end
              end
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      used_q    <= '0;
      ex_hit_q  <= 1'b0;
      fr_hit_q  <= 1'b0;
      pr_hit_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_vld_q  <= rd_vld_d;
      used_q    <= used_d;
      ex_hit_q  <= ex_hit_d;
      fr_hit_q  <= fr_hit_d;
      pr_hit_q  <= pr_hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    rd_idx_q <= rd_idx_d;
    ex_idx_q <= ex_idx_d;
    ex_q     <= ex_d;
    fr_idx_q <= fr_idx_d;
    pr_q     <= pr_d;
    out_q    <= out_d;
  end

endmodule

// ----- src/allocation_region_checker_top.sv -----
// Allocation region checker: a table of up to arc_pkg::TABLE_ENTRIES regions held in one
// single-port-read RAM, with a valid bit per entry in flip-flops. Each request
// (insert, free, remove, check) is served in the back end by a scan of the whole table,
// one entry per cycle through the RAM read port. A two-entry request queue in front and a
// result register at the output let requests and results transfer while a scan is running.
// One result per request.
module allocation_region_checker_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  arc_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output arc_pkg::rsp_t rsp_o
);

  logic          q_valid, q_ready;
  arc_pkg::req_t q_data;

  arc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  arc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_data_i   (q_data),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

endmodule

// ----- src/arc_checker.sv -----
`include "assert_macros.svh"

module arc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_o,
  input arc_pkg::req_t req_i,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input arc_pkg::rsp_t rsp_o
);

  // A waiting request stays offered with the same payload.
  `ASSERT_NXT(a_req_hold, clk_i, rst_ni, req_valid_i && !req_ready_o, req_valid_i && $stable(req_i))

  // A stalled result stays offered.
  `ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o)

  // Only defined status codes leave the block.
  `ASSERT_IMP(a_sts_range, clk_i, rst_ni, rsp_valid_o, rsp_o.status <= arc_pkg::STS_FULL)

  // A full table reports no region.
  `ASSERT_IMP(a_full_zero, clk_i, rst_ni, rsp_valid_o && (rsp_o.status == arc_pkg::STS_FULL), (rsp_o.found_base == '0) && (rsp_o.found_length == '0) && !rsp_o.found_active)

  // A miss reports no region.
  `ASSERT_IMP(a_miss_zero, clk_i, rst_ni, rsp_valid_o && (rsp_o.status == arc_pkg::STS_NOT_FOUND), (rsp_o.found_base == '0) && (rsp_o.found_length == '0) && !rsp_o.found_active)

endmodule

bind allocation_region_checker_top arc_checker u_arc_checker (.*);

// ----- tb/sv/allocation_region_checker_top_tb.sv -----
`timescale 1ns / 1ps

module allocation_region_checker_top_tb;
  import arc_pkg::*;

  // Behavioral copy of the region table, used to predict each response.
  class region_scoreboard;
    bit              used [TABLE_ENTRIES];
    bit [AddrW-1:0]  base [TABLE_ENTRIES];
    bit [LenW-1:0]   len  [TABLE_ENTRIES];
    bit              live [TABLE_ENTRIES];
    rsp_t            pending_rsps[$];
    int              errors;

    function void clear();
      foreach (used[i]) begin
        used[i] = 0;
        base[i] = '0;
        len[i] = '0;
        live[i] = 0;
      end
      pending_rsps.delete();
      errors = 0;
    endfunction

    function int find_exact(bit [AddrW-1:0] a);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (used[i] && base[i] == a) return i;
      return -1;
    endfunction

    function int find_below(bit [AddrW-1:0] a, bit strict);
      int best;
      best = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!used[i]) continue;
        if (base[i] > a || (strict && base[i] == a)) continue;
        if (best < 0 || base[i] > base[best]) best = i;
      end
      return best;
    endfunction

    function rsp_t entry_rsp(logic [2:0] st, int idx);
      rsp_t r;
      r = '0;
      r.status = st;
      if (idx >= 0) begin
        r.found_base = base[idx];
        r.found_length = len[idx];
        r.found_active = live[idx];
      end
      return r;
    endfunction

    // Exact base lookup for free and remove, with interior-address detection.
    function int lookup_base(bit [AddrW-1:0] a, output logic [2:0] st);
      int i;
      i = find_exact(a);
      if (i >= 0) begin
        st = STS_OK;
        return i;
      end
      i = find_below(a, 1);
      if (i >= 0 && (64'(a) - 64'(base[i])) < 64'(len[i])) begin
        st = STS_NOT_FIRST;
        return i;
      end
      st = STS_NOT_FOUND;
      return -1;
    endfunction

    // Applies one accepted request and queues its expected response.
    function void note_request(req_t rq);
      bit [AddrW-1:0] a;
      logic [2:0] st;
      int i;
      rsp_t r;
      bit [63:0] off;
      a = rq.address & AddrMask;
      case (rq.req_type)
        REQ_INSERT: begin
          i = find_exact(a);
          if (i < 0) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
              if (!used[i]) break;
          end
          if (i >= TABLE_ENTRIES) begin
            r = entry_rsp(STS_FULL, -1);
          end else begin
            if (!used[i]) begin
              used[i] = 1;
              base[i] = a;
            end
            len[i] = rq.length;
            live[i] = 1;
            r = entry_rsp(STS_OK, i);
          end
        end
        REQ_FREE: begin
          i = lookup_base(a, st);
          if (st == STS_OK) begin
            if (!live[i]) st = STS_DOUBLE_FREE;
            else begin
              live[i] = 0;
              len[i] = '0;
            end
          end
          r = entry_rsp(st, i);
        end
        REQ_REMOVE: begin
          i = lookup_base(a, st);
          r = entry_rsp(st, i);
          if (st == STS_OK) used[i] = 0;
        end
        default: begin
          i = find_below(a, 0);
          if (i < 0) r = entry_rsp(STS_NOT_FOUND, -1);
          else begin
            off = 64'(a) - 64'(base[i]);
            if (off > 64'(len[i])) r = entry_rsp(STS_NOT_FOUND, -1);
            else if (64'(rq.length) > 64'(len[i]) - off) r = entry_rsp(STS_OVERFLOW, i);
            else if (!live[i]) r = entry_rsp(STS_DOUBLE_FREE, i);
            else r = entry_rsp(STS_OK, i);
          end
        end
      endcase
      pending_rsps.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Compares one accepted response with the oldest expectation.
    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        report($sformatf("unexpected response %p", got));
        return;
      end
      want = pending_rsps.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.found_base !== want.found_base)
        report($sformatf("found_base %h, expected %h", got.found_base, want.found_base));
      if (got.found_length !== want.found_length)
        report($sformatf("found_length %h, expected %h", got.found_length,
                         want.found_length));
      if (got.found_active !== want.found_active)
        report($sformatf("found_active %b, expected %b", got.found_active,
                         want.found_active));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic req_valid_i = 0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 0;
  rsp_t rsp_o;

  region_scoreboard sb = new();
  bit no_idle = 0;
  bit stim_done = 0;
  bit [AddrW-1:0] known_bases[$];

  allocation_region_checker_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i(req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Response side: random stalls, checks every transfer.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
    rsp_ready_i <= no_idle || ($urandom_range(99) >= 11);
  end

  // Drives one request and waits for its transfer.
  task automatic send_request(logic [1:0] kind, bit [AddrW-1:0] a, bit [LenW-1:0] l);
    req_t rq;
    rq.req_type = kind;
    rq.address = a;
    rq.length = l;
    while (!no_idle && $urandom_range(99) < 11) begin
      req_valid_i <= 0;
      @(posedge clk_i);
    end
    req_valid_i <= 1;
    req_i <= rq;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(rq);
    if (kind == REQ_INSERT) known_bases.push_back(a);
  endtask

  task automatic wait_drained();
    req_valid_i <= 0;
    while (sb.pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  function automatic bit [AddrW-1:0] rand_addr();
    return AddrW'({$urandom(), $urandom()});
  endfunction

  // Address near a known base, so lookups hit regions often.
  function automatic bit [AddrW-1:0] near_addr();
    bit [AddrW-1:0] b;
    if (known_bases.size() == 0 || $urandom_range(9) == 0) return rand_addr();
    b = known_bases[$urandom_range(known_bases.size() - 1)];
    case ($urandom_range(3))
      0: return b;
      1: return b + $urandom_range(255);
      2: return b - $urandom_range(16);
      default: return b + $urandom_range(4096);
    endcase
  endfunction

  function automatic bit [LenW-1:0] rand_len();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(512);
    endcase
  endfunction

  initial begin
    int kind;
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty table, extremes, interior and double free, overflow.
    send_request(REQ_CHECK, '0, '0);
    send_request(REQ_FREE, 48'h100, 0);
    send_request(REQ_REMOVE, 48'h100, 0);
    send_request(REQ_INSERT, 48'h100, 32'h100);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_CHECK, 48'h180, 32'h80);
    send_request(REQ_CHECK, 48'h180, 32'h81);
    send_request(REQ_CHECK, 48'h200, 32'h0);
    send_request(REQ_CHECK, 48'h201, 32'h0);
    send_request(REQ_FREE, 48'h180, 0);
    send_request(REQ_REMOVE, 48'h180, 0);
    send_request(REQ_FREE, 48'h100, 0);
    send_request(REQ_FREE, 48'h100, 0);
    send_request(REQ_CHECK, 48'h100, 0);
    send_request(REQ_INSERT, 48'h100, 32'h40);
    send_request(REQ_CHECK, '1, '1);
    send_request(REQ_REMOVE, '1, '0);
    send_request(REQ_REMOVE, 48'h100, 0);
    send_request(REQ_CHECK, 48'h0, '1);

    // Fill the table to overflow, then pause until everything has drained.
    for (int i = 0; i < TABLE_ENTRIES + 2; i++)
      send_request(REQ_INSERT, 48'h1000 * (i + 1), 32'h800);
    send_request(REQ_CHECK, 48'h1400, 32'h400);
    wait_drained();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_request(REQ_REMOVE, 48'h1000 * (i + 1), 0);
    known_bases.delete();

    // Random traffic biased toward known regions; a stretch with no idle cycles or response stalls in the middle.
    for (int n = 0; n < 800; n++) begin
      no_idle = (n >= 300 && n < 400);
      kind = $urandom_range(99);
      if (kind < 35)
        send_request(REQ_INSERT, near_addr(), rand_len());
      else if (kind < 55)
        send_request(REQ_FREE, near_addr(), $urandom());
      else if (kind < 70)
        send_request(REQ_REMOVE, near_addr(), $urandom());
      else
        send_request(REQ_CHECK, near_addr(), rand_len());
    end
    no_idle = 0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Safety limit on the whole run.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/arc_pkg.sv
src/arc_ram.sv
src/arc_front.sv
src/arc_back.sv
src/allocation_region_checker_top.sv
src/arc_checker.sv
tb/sv/allocation_region_checker_top_tb.sv
